// File: src/first_match_substring_search_unit_assert.svh
// Assertion macros for the substring search block.
// Define NO_ASSERTIONS to compile them out.
`ifndef FIRST_MATCH_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define FIRST_MATCH_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FMSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fmss assertion failed");

// next-cycle implication
`define FMSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fmss assertion failed");

`else

`define FMSS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define FMSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/fmss_pkg.sv
`timescale 1ns / 1ps

package fmss_pkg;

    // sizes
    localparam int MAX_NEEDLE     = 32;
    localparam int HAYSTACK_LIMIT = 65536;
    localparam int IDX_W          = $clog2(MAX_NEEDLE);
    localparam int LEN_W          = $clog2(MAX_NEEDLE + 1);
    localparam int CNT_W          = $clog2(HAYSTACK_LIMIT + 1);
    localparam int CHAR_W         = 16;
    localparam int POS_W          = 16;
    localparam int CFG_W          = 6;
    localparam int REG_IDX_W      = 1;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_HAY  = 1'b1;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LENGTH = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_CASE_FOLD     = 1'd1;

    // ASCII upper case range
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 16'h0041;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 16'h005A;
    localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 16'h0020;

    // control broadcast to every cell
    typedef struct packed {
        logic              hay_en;
        logic              clear;
        logic              fold;
        logic [CHAR_W-1:0] hay_char;
    } cell_ctl_t;

    // fold ASCII A-Z to lower case when enabled
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic              fold);
        logic [CHAR_W-1:0] r;
        r = c;
        if (fold && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z))
        begin
            r = c + ASCII_CASE_OFS;
        end
        return r;
    endfunction

endpackage

// File: src/fmss_if.sv
`timescale 1ns / 1ps

// input word channel: needle loads and haystack characters
interface fmss_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [fmss_pkg::IDX_W-1:0]          needle_index;
    logic [fmss_pkg::CHAR_W-1:0]         char_value;
    logic                                last_char;

    modport source (output valid, command, needle_index, char_value, last_char,
                    input ready);
    modport sink   (input valid, command, needle_index, char_value, last_char,
                    output ready);
endinterface

// result word channel
interface fmss_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [fmss_pkg::POS_W-1:0]  match_position;
    logic                        too_long;

    modport source (output valid, found, match_position, too_long, input ready);
    modport sink   (input valid, found, match_position, too_long, output ready);
endinterface

// File: src/fmss_cell.sv
`timescale 1ns / 1ps

// One needle position: holds its needle character and its partial-match bit,
// and hands the bit to the next cell.
module fmss_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_en,
    input  logic [fmss_pkg::CHAR_W-1:0]   load_char,
    input  fmss_pkg::cell_ctl_t           ctl,
    input  logic                          prev_match,
    input  logic                          is_tail,
    output logic                          match,
    output logic                          hit
);

    logic [fmss_pkg::CHAR_W-1:0] needle_reg;
    logic                        match_reg;
    logic                        match_next;
    logic                        eq;

    // needle character, no reset
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            needle_reg <= load_char;
        end
    end

    // compare against the broadcast haystack character
    always_comb
    begin
        eq         = (ctl.hay_char == fmss_pkg::fold_char(needle_reg, ctl.fold));
        match_next = prev_match && eq;
    end

    // partial-match bit, cleared at the end of a search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.hay_en)
        begin
            match_reg <= ctl.clear ? 1'b0 : match_next;
        end
    end

    assign match = match_reg;
    assign hit   = match_next && is_tail;

endmodule

// File: src/first_match_substring_search_unit.sv
`timescale 1ns / 1ps

// Channel   Modport  Words
// items     sink     needle loads and haystack characters
// results   source   found / match_position / too_long, one per search
// cfg       write    needle_length (0), case_fold (1)
//
// One input word is taken per cycle; a result shows in the cycle after the
// last haystack character is taken. The needle is spread over a row of
// MAX_NEEDLE cells whose match bits shift one cell per haystack word.
// Input ready drops only while a result waits and results.ready is low.
// Reset clears search state and config registers; needle characters are not reset.
module first_match_substring_search_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    fmss_in_if.sink                           items,
    fmss_out_if.source                        results,
    input  logic                              write_enable,
    input  logic [fmss_pkg::REG_IDX_W-1:0]    reg_index,
    input  logic [fmss_pkg::CFG_W-1:0]        write_data
);

    localparam int N = fmss_pkg::MAX_NEEDLE;

    logic [fmss_pkg::LEN_W-1:0]  len_reg;
    logic                        fold_reg;

    logic [fmss_pkg::CNT_W-1:0]  cnt_reg;
    logic                        seen_reg;
    logic [fmss_pkg::POS_W-1:0]  pos_reg;
    logic                        ovf_reg;

    logic                        res_valid_reg;
    logic                        res_found_reg;
    logic [fmss_pkg::POS_W-1:0]  res_pos_reg;
    logic                        res_long_reg;

    logic                        item_acc;
    logic                        load_acc;
    logic                        hay_acc;
    logic                        hay_last;
    fmss_pkg::cell_ctl_t         ctl;
    logic [N-1:0]                pm;
    logic [N-1:0]                hit;
    logic                        new_hit;
    logic                        overflow_now;
    logic [fmss_pkg::CNT_W-1:0]  start;
    logic [fmss_pkg::POS_W-1:0]  start_sat;
    logic                        seen_next;
    logic [fmss_pkg::POS_W-1:0]  pos_next;
    logic                        ovf_next;
    logic [fmss_pkg::CNT_W-1:0]  cnt_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            fold_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                fmss_pkg::REG_NEEDLE_LENGTH: len_reg  <= write_data[fmss_pkg::LEN_W-1:0];
                fmss_pkg::REG_CASE_FOLD:     fold_reg <= write_data[0];
                default:                     len_reg  <= len_reg;
            endcase
        end
    end

    // handshake
    assign items.ready = !res_valid_reg || results.ready;
    assign item_acc    = items.valid && items.ready;
    assign load_acc    = item_acc && (items.command == fmss_pkg::CMD_LOAD);
    assign hay_acc     = item_acc && (items.command == fmss_pkg::CMD_HAY);
    assign hay_last    = hay_acc && items.last_char;

    // broadcast control
    always_comb
    begin
        ctl.hay_en   = hay_acc;
        ctl.clear    = items.last_char;
        ctl.fold     = fold_reg;
        ctl.hay_char = fmss_pkg::fold_char(items.char_value, fold_reg);
    end

    // row of cells
    for (genvar j = 0; j < N; j++)
    begin : g_cell
        logic prev;
        if (j == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_body
            assign prev = pm[j-1];
        end

        fmss_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (load_acc && (items.needle_index == fmss_pkg::IDX_W'(j))),
            .load_char  (items.char_value),
            .ctl        (ctl),
            .prev_match (prev),
            .is_tail    (len_reg == fmss_pkg::LEN_W'(j + 1)),
            .match      (pm[j]),
            .hit        (hit[j])
        );
    end

    // position tracking
    always_comb
    begin
        overflow_now = (cnt_reg == fmss_pkg::CNT_W'(fmss_pkg::HAYSTACK_LIMIT));
        new_hit      = (|hit) && !seen_reg;
        start        = cnt_reg + fmss_pkg::CNT_W'(1) - fmss_pkg::CNT_W'(len_reg);
        start_sat    = (start > fmss_pkg::CNT_W'(fmss_pkg::POS_MAX)) ?
                       fmss_pkg::POS_MAX : start[fmss_pkg::POS_W-1:0];
        seen_next    = seen_reg || new_hit;
        pos_next     = new_hit ? start_sat : pos_reg;
        ovf_next     = ovf_reg || overflow_now;
        cnt_next     = overflow_now ? cnt_reg : cnt_reg + fmss_pkg::CNT_W'(1);
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            seen_reg <= 1'b0;
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (hay_acc)
        begin
            if (items.last_char)
            begin
                cnt_reg  <= '0;
                seen_reg <= 1'b0;
                pos_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                cnt_reg  <= cnt_next;
                seen_reg <= seen_next;
                pos_reg  <= pos_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (hay_last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // output word payload; empty needle always matches at zero
    always_ff @(posedge clk)
    begin
        if (hay_last)
        begin
            res_found_reg <= (len_reg == '0) ? 1'b1 : seen_next;
            res_pos_reg   <= (len_reg == '0) ? '0 : pos_next;
            res_long_reg  <= ovf_next;
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.found          = res_found_reg;
    assign results.match_position = res_pos_reg;
    assign results.too_long       = res_long_reg;

    `include "first_match_substring_search_unit_assert.svh"

    `FMSS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= fmss_pkg::CNT_W'(fmss_pkg::HAYSTACK_LIMIT))
    `FMSS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, hay_last, res_valid_reg)
    `FMSS_ASSERT_NEXT(a_last_clears, clk, rst_n, hay_last, (cnt_reg == '0) && !seen_reg && !ovf_reg)
    `FMSS_ASSERT_NOW(a_pos_only_when_seen, clk, rst_n, !seen_reg, pos_reg == '0)

endmodule
